>>> rtl/swr_pkg.sv
// shared types and constants of the sliding window receiver
package swr_pkg;

	// received packet types
	localparam logic [2:0] KIND_SYN        = 3'd0;
	localparam logic [2:0] KIND_SYNACK_ACK = 3'd1;
	localparam logic [2:0] KIND_DATA       = 3'd2;
	localparam logic [2:0] KIND_FIN        = 3'd3;
	localparam logic [2:0] KIND_FINACK     = 3'd4;

	// result word kinds
	localparam logic OUT_CONTROL = 1'b0;
	localparam logic OUT_DELIVER = 1'b1;

	// sent packet types
	localparam logic [2:0] FLAG_NONE   = 3'd0;
	localparam logic [2:0] FLAG_SYNACK = 3'd1;
	localparam logic [2:0] FLAG_ACK    = 3'd2;
	localparam logic [2:0] FLAG_FINACK = 3'd4;

	// ack variants
	localparam logic [1:0] NOTE_IN_ORDER    = 2'd0;
	localparam logic [1:0] NOTE_ONE_MISSING = 2'd1;
	localparam logic [1:0] NOTE_WINDOW_FULL = 2'd2;
	localparam logic [1:0] NOTE_DUPLICATE   = 2'd3;

	// packets this far or further behind the expected number are stale
	localparam int unsigned WINDOW = 3;

	// reorder slots
	localparam int unsigned NSLOT = 2;
	localparam logic SLOT_NEXT  = 1'b0;
	localparam logic SLOT_AFTER = 1'b1;

	// one held packet
	typedef struct packed {
		logic [31:0] seq;
		logic [31:0] payload;
	} slot_t;

	// one result word
	typedef struct packed {
		logic        out_kind;
		logic [2:0]  flag;
		logic [1:0]  ack_note;
		logic [31:0] conn_id;
		logic [31:0] seq;
		logic [31:0] payload;
		logic        last;
	} res_t;

endpackage

>>> rtl/swr_ram.sv
// generic single write port ram with registered read
module swr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/swr_out_reg.sv
// output register between the sequencer and the master stream side
module swr_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  swr_pkg::res_t din,
	output logic          free,
	output logic          m_tvalid,
	input  logic          m_tready,
	output swr_pkg::res_t dout
);

	import swr_pkg::*;

	logic valid_q;
	res_t data_q;

	// a new word may enter when empty or when the held word leaves
	assign free = !valid_q || m_tready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// held word
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= din;
		end
	end

	assign m_tvalid = valid_q;
	assign dout     = data_q;

endmodule

>>> rtl/sliding_window_receiver.sv
// top level of the sliding window receiver: sequencer, connection state and slot buffer
//
// Receiver end of a selective-repeat link for one connection. Each input word is one
// received packet; each output word is a control packet to send back or a payload
// delivered in order. The two reorder slots live in a small ram with one read port, so
// every packet is accepted in ST_IDLE and both slots are read in turn (ST_IDLE, ST_RD1)
// before it is decided in ST_DECIDE. An in-order data packet goes on through ST_DELIV,
// ST_REL once for each held packet it releases, and ST_ALIGN, since the ack, the
// delivery and each release go out one word per cycle through the output register when
// the output side does not stall, and ST_ALIGN realigns a held packet left behind a gap.
// Stalls on the output side hold the sequencer. No clearing pass is needed after reset.
module sliding_window_receiver (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // conn_id, seq, payload
	input  logic [3:0]  s_tuser,   // kind, crc_ok
	// master side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // out_conn_id, out_seq, out_payload
	output logic [5:0]  m_tuser,   // out_kind, flag, ack_note
	output logic        m_tlast,
	// configuration
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	import swr_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_RD1    = 6'b000010,
		ST_DECIDE = 6'b000100,
		ST_DELIV  = 6'b001000,
		ST_REL    = 6'b010000,
		ST_ALIGN  = 6'b100000
	} state_t;

	localparam int AW = $clog2(NSLOT);

	state_t state_q, state_d;

	// configuration and connection state
	logic [31:0] assigned_q;
	logic        open_q;
	logic [31:0] open_id_q;
	logic        est_q;
	logic [31:0] exp_q;
	logic [NSLOT-1:0] full_q;

	// latched packet
	logic [2:0]  kind_q;
	logic [31:0] conn_q;
	logic [31:0] seq_q;
	logic [31:0] pl_q;
	logic        crc_q;

	// slot copies read from the ram
	slot_t sl0_q, sl1_q;

	// ram ports
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	slot_t         ram_wdata, ram_rdata;

	// output register ports
	logic out_free, out_load;
	res_t out_d, out_q;

	logic accept;
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	swr_ram #(
		.WIDTH($bits(slot_t)),
		.DEPTH(NSLOT)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	swr_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (out_load),
		.din     (out_d),
		.free    (out_free),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.dout    (out_q)
	);

	assign m_tdata = {out_q.payload, out_q.seq, out_q.conn_id};
	assign m_tuser = {out_q.ack_note, out_q.flag, out_q.out_kind};
	assign m_tlast = out_q.last;

	// sequence comparisons, without wrap
	logic        match;
	logic [32:0] s_ext, e_ext;
	logic        stale, eq0, eq1, eq2, older;
	logic [31:0] seq_inc;

	assign match   = open_q && (conn_q == open_id_q);
	assign s_ext   = {1'b0, seq_q};
	assign e_ext   = {1'b0, exp_q};
	assign stale   = (s_ext + 33'(WINDOW)) <= e_ext;
	assign eq0     = (seq_q == exp_q);
	assign eq1     = (s_ext == e_ext + 33'd1);
	assign eq2     = (s_ext == e_ext + 33'd2);
	assign older   = (seq_q < exp_q);
	assign seq_inc = seq_q + 32'd1;

	// packet decision
	logic  dec_has, dec_open, dec_est, dec_close, dec_clear, dec_wr, dec_deliv;
	logic  dec_slot;
	res_t  dec_res;

	always_comb begin
		dec_has   = 1'b0;
		dec_open  = 1'b0;
		dec_est   = 1'b0;
		dec_close = 1'b0;
		dec_clear = 1'b0;
		dec_wr    = 1'b0;
		dec_deliv = 1'b0;
		dec_slot  = SLOT_NEXT;
		dec_res   = '{out_kind: OUT_CONTROL, flag: FLAG_ACK, ack_note: NOTE_IN_ORDER,
			conn_id: conn_q, seq: seq_q, payload: 32'd0, last: 1'b1};
		if (crc_q) begin
			case (kind_q)
				KIND_SYN: begin
					dec_has      = 1'b1;
					dec_res.flag = FLAG_SYNACK;
					if (match) begin
						dec_res.conn_id = open_id_q;
					end else begin
						dec_res.conn_id = assigned_q;
						dec_open        = 1'b1;
						dec_clear       = 1'b1;
					end
				end
				KIND_SYNACK_ACK: begin
					if (match) begin
						dec_est   = 1'b1;
						dec_clear = 1'b1;
					end
				end
				KIND_DATA: begin
					if (match && est_q && !stale) begin
						if (eq0) begin
							dec_has      = 1'b1;
							dec_deliv    = 1'b1;
							dec_res.last = 1'b0;
						end else if (eq1) begin
							dec_has          = 1'b1;
							dec_wr           = 1'b1;
							dec_slot         = SLOT_NEXT;
							dec_res.ack_note = NOTE_ONE_MISSING;
						end else if (eq2) begin
							dec_has          = 1'b1;
							dec_wr           = 1'b1;
							dec_slot         = SLOT_AFTER;
							dec_res.ack_note = NOTE_WINDOW_FULL;
						end else if (older) begin
							dec_has          = 1'b1;
							dec_res.ack_note = NOTE_DUPLICATE;
						end
					end
				end
				KIND_FIN: begin
					if (match && est_q) begin
						dec_has      = 1'b1;
						dec_res.flag = FLAG_FINACK;
					end
				end
				KIND_FINACK: begin
					if (match) begin
						dec_close = 1'b1;
						dec_clear = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// delivery of the current packet: does a held packet follow it
	logic deliv_m0, deliv_m1, deliv_more;
	assign deliv_m0   = full_q[SLOT_NEXT] && (sl0_q.seq == seq_inc);
	assign deliv_m1   = full_q[SLOT_AFTER] && (sl1_q.seq == seq_inc);
	assign deliv_more = deliv_m0 || deliv_m1;

	// release of held packets, lowest matching slot first
	logic  rel_m0, rel_pick, rel_more;
	slot_t rel_slot, rel_other;
	logic [31:0] rel_next;
	assign rel_m0    = full_q[SLOT_NEXT] && (sl0_q.seq == exp_q);
	assign rel_pick  = rel_m0 ? SLOT_NEXT : SLOT_AFTER;
	assign rel_slot  = rel_m0 ? sl0_q : sl1_q;
	assign rel_other = rel_m0 ? sl1_q : sl0_q;
	assign rel_next  = rel_slot.seq + 32'd1;
	assign rel_more  = full_q[!rel_pick] && (rel_other.seq == rel_next);

	// realign a packet held behind a gap
	logic align;
	assign align = !full_q[SLOT_NEXT] && full_q[SLOT_AFTER] && (sl1_q.seq == exp_q + 32'd1);

	// sequencer, output word and ram access
	logic go;
	assign go = !dec_has || out_free;

	always_comb begin
		state_d   = state_q;
		out_load  = 1'b0;
		out_d     = dec_res;
		ram_re    = 1'b0;
		ram_raddr = AW'(SLOT_NEXT);
		ram_we    = 1'b0;
		ram_waddr = AW'(SLOT_NEXT);
		ram_wdata = '{seq: seq_q, payload: pl_q};
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ram_re  = 1'b1;
					state_d = ST_RD1;
				end
			end
			ST_RD1: begin
				ram_re    = 1'b1;
				ram_raddr = AW'(SLOT_AFTER);
				state_d   = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (go) begin
					out_load  = dec_has;
					ram_we    = dec_wr;
					ram_waddr = AW'(dec_slot);
					state_d   = dec_deliv ? ST_DELIV : ST_IDLE;
				end
			end
			ST_DELIV: begin
				out_d = '{out_kind: OUT_DELIVER, flag: FLAG_NONE, ack_note: NOTE_IN_ORDER,
					conn_id: open_id_q, seq: seq_q, payload: pl_q, last: !deliv_more};
				if (out_free) begin
					out_load = 1'b1;
					state_d  = deliv_more ? ST_REL : ST_ALIGN;
				end
			end
			ST_REL: begin
				out_d = '{out_kind: OUT_DELIVER, flag: FLAG_NONE, ack_note: NOTE_IN_ORDER,
					conn_id: open_id_q, seq: rel_slot.seq, payload: rel_slot.payload,
					last: !rel_more};
				if (out_free) begin
					out_load = 1'b1;
					state_d  = rel_more ? ST_REL : ST_ALIGN;
				end
			end
			ST_ALIGN: begin
				ram_we    = align;
				ram_wdata = sl1_q;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// assigned id, never zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			assigned_q <= 32'd1;
		end else if (cfg_we) begin
			assigned_q <= (cfg_wdata != 32'd0) ? cfg_wdata : 32'd1;
		end
	end

	// connection state and slot flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q    <= 1'b0;
			open_id_q <= 32'd0;
			est_q     <= 1'b0;
			exp_q     <= 32'd0;
			full_q    <= '0;
		end else begin
			case (state_q)
				ST_DECIDE: begin
					if (go) begin
						if (dec_open) begin
							open_q    <= 1'b1;
							open_id_q <= assigned_q;
							est_q     <= 1'b0;
						end
						if (dec_est) begin
							est_q <= 1'b1;
							exp_q <= seq_inc;
						end
						if (dec_close) begin
							open_q <= 1'b0;
							est_q  <= 1'b0;
						end
						if (dec_clear) begin
							full_q <= '0;
						end
						if (dec_wr) begin
							full_q[dec_slot] <= 1'b1;
						end
					end
				end
				ST_DELIV: begin
					if (out_free) begin
						exp_q <= seq_inc;
					end
				end
				ST_REL: begin
					if (out_free) begin
						full_q[rel_pick] <= 1'b0;
						exp_q            <= rel_next;
					end
				end
				ST_ALIGN: begin
					if (align) begin
						full_q[SLOT_NEXT]  <= 1'b1;
						full_q[SLOT_AFTER] <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// latched packet word
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= s_tuser[2:0];
			crc_q  <= s_tuser[3];
			conn_q <= s_tdata[31:0];
			seq_q  <= s_tdata[63:32];
			pl_q   <= s_tdata[95:64];
		end
	end

	// slot copies, one ram read each
	always_ff @(posedge clk) begin
		if (state_q == ST_RD1) begin
			sl0_q <= ram_rdata;
		end
		if (state_q == ST_DECIDE) begin
			sl1_q <= ram_rdata;
		end
	end

endmodule

>>> tb/sliding_window_receiver_tb.sv
// self-checking testbench for the sliding window receiver: stream driver, monitor and predictor
module sliding_window_receiver_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import swr_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int QUIET_CYCLES = 12;
	localparam int MAX_PRINTS = 50;

	// one received packet waiting to be driven
	typedef struct {
		logic [2:0]  kind;
		logic [31:0] conn_id;
		logic [31:0] seq;
		logic [31:0] payload;
		logic        crc_ok;
		logic        hold;     // wait until every expected word has come out
	} packet_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;   // conn_id, seq, payload
	logic [3:0]  s_tuser = '0;   // kind, crc_ok
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;        // out_conn_id, out_seq, out_payload
	logic [5:0]  m_tuser;        // out_kind, flag, ack_note
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;

	packet_t pend_q [$];
	res_t    want_q [$];

	int   errors = 0;
	int   cycles = 0;
	int   words_seen = 0;
	int   send_wait = 0;
	int   recv_wait = 0;
	logic in_fire = 1'b0;
	logic out_fire = 1'b0;
	logic calm = 1'b0;

	// predicted link state
	logic        link_open = 1'b0;
	logic [31:0] link_id = '0;
	logic        link_up = 1'b0;
	logic [31:0] next_seq = '0;
	logic [31:0] grant_id = 32'd1;
	logic        held_full [NSLOT] = '{default: 1'b0};
	logic [31:0] held_seq [NSLOT];
	logic [31:0] held_pl [NSLOT];

	sliding_window_receiver dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, 3);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("mismatch at word %0d: %s got %0h want %0h", words_seen, what, got, want);
	endtask

	task automatic add_result(input logic ok, input logic [2:0] fl, input logic [1:0] note,
			input logic [31:0] id, input logic [31:0] sq, input logic [31:0] pl);
		res_t r;
		r.out_kind = ok;
		r.flag = fl;
		r.ack_note = note;
		r.conn_id = id;
		r.seq = sq;
		r.payload = pl;
		r.last = 1'b0;
		want_q.push_back(r);
	endtask

	// predicted words for one accepted packet
	task automatic predict_packet(input logic [2:0] kind, input logic [31:0] id,
			input logic [31:0] seq, input logic [31:0] pl, input logic ok);
		logic        match;
		logic [32:0] s33;
		logic [32:0] e33;
		logic        moved;
		int          n0;
		int          i;
		match = link_open && id == link_id;
		s33 = {1'b0, seq};
		e33 = {1'b0, next_seq};
		n0 = want_q.size();
		if (ok) begin
			case (kind)
				KIND_SYN: begin
					if (match) begin
						add_result(OUT_CONTROL, FLAG_SYNACK, NOTE_IN_ORDER, link_id, seq, '0);
					end else begin
						add_result(OUT_CONTROL, FLAG_SYNACK, NOTE_IN_ORDER, grant_id, seq, '0);
						link_open = 1'b1;
						link_id = grant_id;
						link_up = 1'b0;
						held_full[SLOT_NEXT] = 1'b0;
						held_full[SLOT_AFTER] = 1'b0;
					end
				end
				KIND_SYNACK_ACK: begin
					if (match) begin
						link_up = 1'b1;
						held_full[SLOT_NEXT] = 1'b0;
						held_full[SLOT_AFTER] = 1'b0;
						next_seq = seq + 32'd1;
					end
				end
				KIND_DATA: begin
					if (match && link_up && !(s33 + 33'(WINDOW) <= e33)) begin
						if (s33 == e33) begin
							add_result(OUT_CONTROL, FLAG_ACK, NOTE_IN_ORDER, id, seq, '0);
							add_result(OUT_DELIVER, FLAG_NONE, NOTE_IN_ORDER, link_id, seq, pl);
							next_seq = seq + 32'd1;
							// release held packets while they stay consecutive
							moved = 1'b1;
							while (moved) begin
								moved = 1'b0;
								for (i = 0; i < NSLOT; i++) begin
									if (held_full[i] && held_seq[i] == next_seq) begin
										add_result(OUT_DELIVER, FLAG_NONE, NOTE_IN_ORDER, link_id,
											held_seq[i], held_pl[i]);
										next_seq = held_seq[i] + 32'd1;
										held_full[i] = 1'b0;
										moved = 1'b1;
									end
								end
							end
							// a packet left behind a gap moves to the near slot
							if (!held_full[SLOT_NEXT] && held_full[SLOT_AFTER] &&
									held_seq[SLOT_AFTER] == next_seq + 32'd1) begin
								held_full[SLOT_NEXT] = 1'b1;
								held_seq[SLOT_NEXT] = held_seq[SLOT_AFTER];
								held_pl[SLOT_NEXT] = held_pl[SLOT_AFTER];
								held_full[SLOT_AFTER] = 1'b0;
							end
						end else if (s33 == e33 + 33'd1) begin
							held_full[SLOT_NEXT] = 1'b1;
							held_seq[SLOT_NEXT] = seq;
							held_pl[SLOT_NEXT] = pl;
							add_result(OUT_CONTROL, FLAG_ACK, NOTE_ONE_MISSING, id, seq, '0);
						end else if (s33 == e33 + 33'd2) begin
							held_full[SLOT_AFTER] = 1'b1;
							held_seq[SLOT_AFTER] = seq;
							held_pl[SLOT_AFTER] = pl;
							add_result(OUT_CONTROL, FLAG_ACK, NOTE_WINDOW_FULL, id, seq, '0);
						end else if (s33 < e33) begin
							add_result(OUT_CONTROL, FLAG_ACK, NOTE_DUPLICATE, id, seq, '0);
						end
					end
				end
				KIND_FIN: begin
					if (match && link_up)
						add_result(OUT_CONTROL, FLAG_FINACK, NOTE_IN_ORDER, id, seq, '0);
				end
				KIND_FINACK: begin
					if (match) begin
						link_open = 1'b0;
						link_up = 1'b0;
						held_full[SLOT_NEXT] = 1'b0;
						held_full[SLOT_AFTER] = 1'b0;
					end
				end
				default: ;
			endcase
		end
		if (want_q.size() > n0)
			want_q[want_q.size() - 1].last = 1'b1;
	endtask

	// monitor: timeout, prediction on input words, checks on output words
	always @(posedge clk) begin : watch_ports
		res_t got;
		res_t exp_r;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("sliding_window_receiver test failed");
			$finish;
		end else begin
			in_fire <= s_tvalid && s_tready;
			out_fire <= m_tvalid && m_tready;
			if (cfg_we)
				grant_id = (cfg_wdata != 32'd0) ? cfg_wdata : 32'd1;
			if (arst_n && s_tvalid && s_tready)
				predict_packet(s_tuser[2:0], s_tdata[31:0], s_tdata[63:32], s_tdata[95:64],
					s_tuser[3]);
			if (arst_n && m_tvalid && m_tready) begin
				got.out_kind = m_tuser[0];
				got.flag = m_tuser[3:1];
				got.ack_note = m_tuser[5:4];
				got.conn_id = m_tdata[31:0];
				got.seq = m_tdata[63:32];
				got.payload = m_tdata[95:64];
				got.last = m_tlast;
				if (want_q.size() == 0) begin
					report_mismatch("word with nothing expected, seq", got.seq, 32'd0);
				end else begin
					exp_r = want_q.pop_front();
					if (got.out_kind !== exp_r.out_kind)
						report_mismatch("out_kind", 32'(got.out_kind), 32'(exp_r.out_kind));
					if (got.flag !== exp_r.flag)
						report_mismatch("flag", 32'(got.flag), 32'(exp_r.flag));
					if (got.ack_note !== exp_r.ack_note)
						report_mismatch("ack_note", 32'(got.ack_note), 32'(exp_r.ack_note));
					if (got.conn_id !== exp_r.conn_id)
						report_mismatch("out_conn_id", got.conn_id, exp_r.conn_id);
					if (got.seq !== exp_r.seq)
						report_mismatch("out_seq", got.seq, exp_r.seq);
					if (got.payload !== exp_r.payload)
						report_mismatch("out_payload", got.payload, exp_r.payload);
					if (got.last !== exp_r.last)
						report_mismatch("last", 32'(got.last), 32'(exp_r.last));
				end
				words_seen++;
			end
		end
	end

	// packet driver with random gaps
	always @(negedge clk) begin : drive_packets
		int      w;
		logic    nv;
		packet_t p;
		if (arst_n && !(s_tvalid && !in_fire)) begin
			w = send_wait;
			nv = 1'b0;
			if (s_tvalid)
				w = draw_gap();
			if (w > 0) begin
				w--;
			end else if (pend_q.size() > 0 && !(pend_q[0].hold && want_q.size() > 0)) begin
				p = pend_q.pop_front();
				nv = 1'b1;
				s_tdata <= {p.payload, p.seq, p.conn_id};
				s_tuser <= {p.crc_ok, p.kind};
			end
			send_wait = w;
			s_tvalid <= nv;
		end
	end

	// result sink with random stalls
	always @(negedge clk) begin : sink_results
		int w;
		if (arst_n) begin
			w = recv_wait;
			if (out_fire)
				w = draw_gap();
			if (w > 0) begin
				m_tready <= 1'b0;
				w--;
			end else begin
				m_tready <= 1'b1;
			end
			recv_wait = w;
		end
	end

	task automatic add_pkt(input logic [2:0] kind, input logic [31:0] id, input logic [31:0] seq,
			input logic [31:0] pl, input logic ok, input logic hold);
		packet_t p;
		p.kind = kind;
		p.conn_id = id;
		p.seq = seq;
		p.payload = pl;
		p.crc_ok = ok;
		p.hold = hold;
		pend_q.push_back(p);
	endtask

	// junk packet near the current sequence that must not tear the link down
	task automatic add_noise(input logic [31:0] sid, input logic [31:0] near);
		logic [2:0]  k;
		logic        ok;
		logic [31:0] id;
		k = 3'($urandom_range(0, 7));
		ok = 1'($urandom_range(0, 1));
		id = $urandom_range(0, 1) ? sid : $urandom();
		if (k == KIND_SYN || k == KIND_SYNACK_ACK || k == KIND_FINACK)
			ok = 1'b0;
		add_pkt(k, id, near + $urandom_range(0, 8) - 32'd4, $urandom(), ok, 1'b0);
	endtask

	// whole sessions: open, establish, shuffled data in blocks of three, and a close at random
	task automatic random_traffic(input int n_items, input logic [31:0] sid);
		int          made;
		int          a;
		int          b;
		int          k;
		logic [31:0] cur;
		logic [31:0] tmp;
		logic [31:0] blk [3];
		logic [31:0] lost [$];
		made = 0;
		while (made < n_items) begin
			add_pkt(KIND_SYN, $urandom(), $urandom(), $urandom(), 1'b1, $urandom_range(0, 5) == 0);
			made++;
			if ($urandom_range(0, 3) == 0) begin
				add_pkt(KIND_SYN, sid, $urandom(), $urandom(), 1'b1, 1'b0);
				made++;
			end
			if ($urandom_range(0, 7) == 0) begin
				add_pkt(KIND_DATA, sid, $urandom(), $urandom(), 1'b1, 1'b0);
				made++;
			end
			case ($urandom_range(0, 3))
				1: cur = 32'hFFFF_FFFF - $urandom_range(0, 6);
				2: cur = $urandom_range(0, 6);
				default: cur = $urandom();
			endcase
			add_pkt(KIND_SYNACK_ACK, sid, cur - 32'd1, $urandom(), 1'b1, 1'b0);
			made++;
			repeat ($urandom_range(1, 8)) begin
				blk[0] = cur;
				blk[1] = cur + 32'd1;
				blk[2] = cur + 32'd2;
				repeat (3) begin
					a = $urandom_range(0, 2);
					b = $urandom_range(0, 2);
					tmp = blk[a];
					blk[a] = blk[b];
					blk[b] = tmp;
				end
				lost.delete();
				for (k = 0; k < 3; k++) begin
					if ($urandom_range(0, 11) == 0)
						lost.push_back(blk[k]);
					else
						add_pkt(KIND_DATA, sid, blk[k], $urandom(), 1'b1, 1'b0);
				end
				// lost packets come again after the rest of the block
				foreach (lost[j])
					add_pkt(KIND_DATA, sid, lost[j], $urandom(), 1'b1, 1'b0);
				made += 3;
				if ($urandom_range(0, 4) == 0) begin
					add_pkt(KIND_DATA, sid, cur - $urandom_range(0, 4), $urandom(), 1'b1, 1'b0);
					made++;
				end
				if ($urandom_range(0, 5) == 0)
					add_noise(sid, cur);
				cur += 32'd3;
			end
			if ($urandom_range(0, 3) != 0) begin
				add_pkt(KIND_FIN, sid, $urandom(), $urandom(), 1'b1, 1'b0);
				made++;
			end
			if ($urandom_range(0, 1) == 0) begin
				add_pkt(KIND_FINACK, sid, $urandom(), $urandom(), 1'b1, 1'b0);
				made++;
			end
		end
	endtask

	// register writes must wait until every word is out and it is quiet; not enforced
	task automatic wait_idle();
		while (pend_q.size() > 0 || s_tvalid || want_q.size() > 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_grant(input logic [31:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// stimulus
	initial begin : stimulus
		logic [31:0] gen_id;
		logic [31:0] grant_vals [4];
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: link setup, wrap of the expected number, buffering, teardown
		add_pkt(KIND_DATA, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0);
		add_pkt(KIND_SYN, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b1, 1'b1);
		add_pkt(KIND_FIN, 32'd1, 32'd9, 32'd0, 1'b1, 1'b0);
		add_pkt(KIND_SYN, 32'd1, 32'hFFFF_FFFF, 32'd0, 1'b1, 1'b0);
		add_pkt(KIND_SYNACK_ACK, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0);
		add_pkt(KIND_SYNACK_ACK, 32'd1, 32'hFFFF_FFFE, 32'd0, 1'b1, 1'b0);
		add_pkt(KIND_DATA, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
		add_pkt(KIND_DATA, 32'd1, 32'd2, 32'd0, 1'b1, 1'b0);
		add_pkt(KIND_DATA, 32'd1, 32'd1, 32'hA5A5_A5A5, 1'b1, 1'b0);
		add_pkt(KIND_DATA, 32'd1, 32'd0, 32'h5A5A_5A5A, 1'b1, 1'b0);
		add_pkt(KIND_DATA, 32'd1, 32'd1, 32'd7, 1'b1, 1'b0);
		add_pkt(KIND_DATA, 32'd1, 32'd0, 32'd7, 1'b1, 1'b0);
		add_pkt(KIND_DATA, 32'd1, 32'd6, 32'd7, 1'b1, 1'b0);
		add_pkt(KIND_DATA, 32'd1, 32'd5, 32'h0000_0055, 1'b1, 1'b0);
		add_pkt(KIND_DATA, 32'd1, 32'd3, 32'h0000_0033, 1'b1, 1'b0);
		add_pkt(KIND_DATA, 32'd1, 32'd4, 32'h0000_0044, 1'b1, 1'b0);
		add_pkt(KIND_DATA, 32'd1, 32'd6, 32'd6, 1'b0, 1'b0);
		add_pkt(3'd5, 32'd1, 32'd6, 32'd0, 1'b1, 1'b0);
		add_pkt(3'd6, 32'd1, 32'd6, 32'd0, 1'b1, 1'b0);
		add_pkt(3'd7, 32'd1, 32'd6, 32'd0, 1'b1, 1'b0);
		add_pkt(KIND_FIN, 32'd2, 32'd77, 32'd0, 1'b1, 1'b0);
		add_pkt(KIND_FIN, 32'd1, 32'd77, 32'd0, 1'b1, 1'b0);
		add_pkt(KIND_FINACK, 32'd0, 32'd78, 32'd0, 1'b1, 1'b0);
		add_pkt(KIND_FINACK, 32'd1, 32'd78, 32'd0, 1'b1, 1'b0);
		add_pkt(KIND_DATA, 32'd1, 32'd6, 32'd0, 1'b1, 1'b0);
		add_pkt(KIND_SYNACK_ACK, 32'd1, 32'd0, 32'd0, 1'b1, 1'b0);
		wait_idle();

		// random sessions under several written ids, zero and all ones among them
		grant_vals[0] = 32'd0;
		grant_vals[1] = 32'hFFFF_FFFF;
		grant_vals[2] = $urandom();
		grant_vals[3] = 32'd1;
		for (int ph = 0; ph < 4; ph++) begin
			write_grant(grant_vals[ph]);
			gen_id = (grant_vals[ph] != 32'd0) ? grant_vals[ph] : 32'd1;
			calm = (ph == 2);
			random_traffic(110, gen_id);
			wait_idle();
		end

		if (errors == 0) begin
			$display("sliding_window_receiver test passed");
		end else begin
			$display("sliding_window_receiver test failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/swr_pkg.sv
rtl/swr_ram.sv
rtl/swr_out_reg.sv
rtl/sliding_window_receiver.sv
tb/sliding_window_receiver_tb.sv
